FILE: sv/tkps_pkg.sv
// types and constants shared by the top-k pose selector modules
`default_nettype none

package tkps_pkg;

  localparam int MaxKept  = 16;
  localparam int IdxW     = $clog2(MaxKept);
  localparam int CountW   = $clog2(MaxKept + 1);
  localparam int SkelW    = 6;
  localparam int AngW     = 8;
  localparam int PidW     = 16;
  localparam int LikW     = 32;
  localparam int LimW     = 5;
  localparam int RankW    = 4;
  localparam int QDepth   = 2;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  typedef struct packed {
    logic [PidW-1:0]  point_id;
    logic [SkelW-1:0] skeleton_index;
    logic [AngW-1:0]  angle_index;
    logic [LikW-1:0]  likelihood;
    logic             point_end;
    logic             set_end;
  } in_beat_t;

  typedef struct packed {
    logic [PidW-1:0]  best_point_id;
    logic [SkelW-1:0] best_skeleton;
    logic [AngW-1:0]  best_angle;
    logic [LikW-1:0]  best_likelihood;
    logic [RankW-1:0] rank;
    logic             final_result;
  } out_beat_t;

  typedef struct packed {
    logic [LikW-1:0]  lik;
    logic [PidW-1:0]  pid;
    logic [SkelW-1:0] skel;
    logic [AngW-1:0]  ang;
  } sample_t;

  typedef struct packed {
    sample_t s;
    logic    set_end;
  } qent_t;

  typedef struct packed {
    logic  valid;
    qent_t data;
  } q_head_t;

  typedef enum logic {
    BkIdle,
    BkReport
  } back_state_e;

endpackage

`default_nettype wire

FILE: sv/tkps_front.sv
// front end: running per-point maximum and closed-point sample extraction
`default_nettype none

module tkps_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire tkps_pkg::in_beat_t in_data_i,
  input  wire logic              q_full_i,
  output logic                   push_o,
  output tkps_pkg::qent_t        push_data_o
);
  import tkps_pkg::*;

  logic             pip_q, pip_d;
  logic [LikW-1:0]  max_q, max_d;
  logic [SkelW-1:0] skel_q, skel_d;
  logic [AngW-1:0]  ang_q, ang_d;
  logic             acc, take, closing;

  assign in_stall_o = q_full_i;
  assign acc        = in_valid_i & ~q_full_i;
  assign take       = ~pip_q | (in_data_i.likelihood > max_q);
  assign closing    = in_data_i.point_end | in_data_i.set_end;

  always_comb begin
    max_d  = max_q;
    skel_d = skel_q;
    ang_d  = ang_q;
    pip_d  = pip_q;
    if (acc) begin
      if (take) begin
        max_d  = in_data_i.likelihood;
        skel_d = in_data_i.skeleton_index;
        ang_d  = in_data_i.angle_index;
      end
      pip_d = ~closing;
    end
  end

  assign push_o              = acc & closing;
  assign push_data_o.s.lik   = max_d;
  assign push_data_o.s.pid   = in_data_i.point_id;
  assign push_data_o.s.skel  = skel_d;
  assign push_data_o.s.ang   = ang_d;
  assign push_data_o.set_end = in_data_i.set_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pip_q  <= 1'b0;
      max_q  <= '0;
      skel_q <= '0;
      ang_q  <= '0;
    end else begin
      pip_q  <= pip_d;
      max_q  <= max_d;
      skel_q <= skel_d;
      ang_q  <= ang_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/tkps_queue.sv
// two-entry queue of closed-point samples between front and back
`default_nettype none

module tkps_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire tkps_pkg::qent_t push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output tkps_pkg::q_head_t    head_o
);
  import tkps_pkg::*;

  qent_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_pop;

  assign full_o      = (cnt_q == QCntW'(QDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.data  = mem_q[rd_q];
  assign do_pop       = pop_i & head_o.valid;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/tkps_back.sv
// back end: sorted kept set with parallel compare-and-shift, and ranked report
`default_nettype none

module tkps_back (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [tkps_pkg::LimW-1:0] cfg_data_i,
  input  wire tkps_pkg::q_head_t      head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output tkps_pkg::out_beat_t         out_data_o
);
  import tkps_pkg::*;

  function automatic logic [CountW-1:0] eff_limit(input logic [LimW-1:0] v);
    logic [CountW-1:0] r;
    if (v == '0) begin
      r = CountW'(1);
    end else if (CountW'(v) > CountW'(MaxKept)) begin
      r = CountW'(MaxKept);
    end else begin
      r = CountW'(v);
    end
    return r;
  endfunction

  back_state_e       state_q, state_d;
  sample_t           kept_q [MaxKept];
  sample_t           kept_d [MaxKept];
  logic [MaxKept-1:0] kept_we;
  logic [LimW-1:0]   max_kept_q, max_kept_d;
  logic [CountW-1:0] count_q, count_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  out_beat_t         out_q, out_d;

  logic [CountW-1:0] lim, new_lim, n;
  logic [IdxW-1:0]   lim_m1;
  logic [MaxKept-1:0] ge;
  logic              full, drop;
  logic              ins_en, load, last, out_free;
  sample_t           s;

  assign s        = head_i.data.s;
  assign lim      = eff_limit(max_kept_q);
  assign new_lim  = eff_limit(cfg_data_i);
  assign lim_m1   = IdxW'(lim - 1'b1);
  assign full     = (count_q >= lim);
  assign drop     = full & ge[lim_m1];
  assign n        = full ? (lim - 1'b1) : count_q;
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign last     = ((CountW'(idx_q) + 1'b1) == count_q);

  always_comb begin
    for (int i = 0; i < MaxKept; i++) begin
      ge[i] = (CountW'(i) < count_q) && (kept_q[i].lik >= s.lik);
    end
  end

  always_comb begin
    for (int i = 0; i < MaxKept; i++) begin
      kept_we[i] = 1'b0;
      kept_d[i]  = kept_q[i];
      if (ins_en && !drop && (CountW'(i) <= n) && !ge[i]) begin
        kept_we[i] = 1'b1;
        if (i == 0) begin
          kept_d[i] = s;
        end else if (ge[i-1]) begin
          kept_d[i] = s;
        end else begin
          kept_d[i] = kept_q[i-1];
        end
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle: begin
        if (head_i.valid && head_i.data.set_end) begin
          state_d = BkReport;
        end
      end
      BkReport: begin
        if (out_free && last) begin
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  // state outputs
  always_comb begin
    pop_o  = 1'b0;
    ins_en = 1'b0;
    load   = 1'b0;
    unique case (state_q)
      BkIdle: begin
        pop_o  = head_i.valid;
        ins_en = head_i.valid;
      end
      BkReport: begin
        load = out_free;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    max_kept_d = max_kept_q;
    count_d    = count_q;
    idx_d      = idx_q;
    if (cfg_we_i) begin
      max_kept_d = cfg_data_i;
      if (count_q > new_lim) begin
        count_d = new_lim;
      end
    end else if (ins_en) begin
      if (!drop) begin
        count_d = n + 1'b1;
      end
      idx_d = '0;
    end else if (load) begin
      idx_d = idx_q + 1'b1;
      if (last) begin
        count_d = '0;
      end
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    if (load) begin
      out_valid_d           = 1'b1;
      out_d.best_point_id   = kept_q[idx_q].pid;
      out_d.best_skeleton   = kept_q[idx_q].skel;
      out_d.best_angle      = kept_q[idx_q].ang;
      out_d.best_likelihood = kept_q[idx_q].lik;
      out_d.rank            = RankW'(idx_q);
      out_d.final_result    = last;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxKept; i++) begin
      if (kept_we[i]) begin
        kept_q[i] <= kept_d[i];
      end
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      max_kept_q  <= LimW'(MaxKept);
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      max_kept_q  <= max_kept_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: sv/top_k_pose_selector.sv
// top-k pose selector: per-point maximum, kept top set, ranked report per set
// report: set-end sample queued, then inserted, then report state loads the output register
// throughput: one beat per cycle unless queue full; one closed point inserted per idle cycle
// a report holds the back end until its last beat; meanwhile a full queue stalls input
// reset: kept count zero, limit 16, running maximum cleared, kept entries not cleared
`default_nettype none

module top_k_pose_selector (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire tkps_pkg::in_beat_t       in_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output tkps_pkg::out_beat_t           out_data_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [tkps_pkg::LimW-1:0] cfg_data_i
);
  import tkps_pkg::*;

  logic    push, q_full, pop;
  qent_t   push_data;
  q_head_t head;

  tkps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  tkps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_o      (head)
  );

  tkps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
